### rtl/life_generation_row_stream_assert.svh
// ---------------------------------------------------------------------------
// Life generation row stream: assertion macros
// Shared concurrent check forms, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STREAM_ASSERT_SVH
`define LIFE_GENERATION_ROW_STREAM_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define LGRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgrs check failed: same-cycle implication");
// next-cycle implication, sampled on clk, off during rst
`define LGRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgrs check failed: next-cycle implication");
`else
`define LGRS_ASSERT_IMP(lbl, ante, cons)
`define LGRS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/lgrs_pkg.sv
// ---------------------------------------------------------------------------
// Life generation row stream package
// Shared widths, cell tap and control types, result beat type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

  localparam int MAX_COLS = 64;
  localparam int COLS_W   = 7;

  // rule constants of B3/S23
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // bits one column shows to its neighbors: above, middle, below
  typedef struct packed {
    logic above;
    logic mid;
    logic below;
  } lgrs_tap_t;

  // per-cycle command broadcast to every column cell
  typedef struct packed {
    logic shift;   // take the arriving row, move middle up
    logic clear;   // drop both held rows
    logic flush;   // below row is dead (emit held bottom row)
    logic single;  // no row held: arriving row stands alone
  } lgrs_ctrl_t;

  // one result beat
  typedef struct packed {
    logic                  frame_end;
    logic [MAX_COLS-1:0]   cells;
  } lgrs_result_t;

  // result buffer status
  typedef struct packed {
    logic       can_push;
    logic [1:0] count;
  } lgrs_buf_stat_t;

endpackage

`default_nettype wire

### rtl/lgrs_cell.sv
// ---------------------------------------------------------------------------
// Life column cell
// Holds one column of the two retained rows and computes that column's next
// generation bit from its own taps and those of its two neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgrs_cell
  import lgrs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire lgrs_ctrl_t ctrl,
  input  wire logic       row_bit,
  input  wire logic       mask_bit,
  input  wire lgrs_tap_t  left_tap,
  input  wire lgrs_tap_t  right_tap,
  output lgrs_tap_t       tap,
  output logic            next_bit
);

  logic       upper_bit;
  logic       mid_bit;
  logic [3:0] count;

  // select the rows this column sees this cycle
  always_comb begin
    if (ctrl.single) begin
      tap.above = 1'b0;
      tap.mid   = row_bit;
      tap.below = 1'b0;
    end else begin
      tap.above = upper_bit;
      tap.mid   = mid_bit;
      tap.below = ctrl.flush ? 1'b0 : row_bit;
    end
  end

  // count the eight neighbors and apply birth / survival
  always_comb begin
    count = 4'(left_tap.above) + 4'(tap.above) + 4'(right_tap.above)
          + 4'(left_tap.mid) + 4'(right_tap.mid)
          + 4'(left_tap.below) + 4'(tap.below) + 4'(right_tap.below);
    next_bit = mask_bit &
               ((count == BIRTH_COUNT) || (tap.mid && (count == SURVIVE_COUNT)));
  end

  // advance or drop the held column bits
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      upper_bit <= 1'b0;
      mid_bit   <= 1'b0;
    end else if (ctrl.shift) begin
      upper_bit <= mid_bit;
      mid_bit   <= row_bit;
    end
  end

endmodule

`default_nettype wire

### rtl/lgrs_out_buf.sv
// ---------------------------------------------------------------------------
// Life result buffer
// Two-entry output register with skid slot; the push side sees only a
// registered status, so the receiver's stall never reaches the input path.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgrs_out_buf
  import lgrs_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lgrs_result_t   push_data,
  output lgrs_buf_stat_t      stat,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output lgrs_result_t        m_beat
);

  logic [1:0]   count;
  logic [1:0]   count_next;
  logic         pop;
  lgrs_result_t ent0;
  lgrs_result_t ent1;

  assign m_tvalid      = (count != 2'd0);
  assign m_beat        = ent0;
  assign pop           = m_tvalid && m_tready;
  assign stat.count    = count;
  assign stat.can_push = (count != 2'd2);

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // move beats through head and skid slots
  always_ff @(posedge clk) begin
    if (count == 2'd2) begin
      if (pop) begin
        ent0 <= ent1;
      end
    end else if (count == 2'd1) begin
      if (push && pop) begin
        ent0 <= push_data;
      end else if (push) begin
        ent1 <= push_data;
      end
    end else begin
      if (push) begin
        ent0 <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/life_generation_row_stream.sv
// ---------------------------------------------------------------------------
// Life generation row stream
// One B3/S23 generation over a streamed grid, built as a chain of columns.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats on s_* carry one grid row each, top to bottom; s_tlast marks
//   the bottom row. Output beats on m_* carry next-generation rows in order;
//   m_tlast marks the next-generation bottom row.
//   The first row of a taller grid gives no beat; a grid of one row pushes
//   its result into the result buffer on acceptance. Every later row pushes
//   the next generation of the row above it on acceptance. A bottom row
//   under a held row also gives its own result in a later flush step, and
//   the block takes no input during that step.
//   Throughput is one row per cycle otherwise, while the result buffer can
//   take a beat, set by the single column chain that computes all columns
//   of a row combinationally.
//   cfg_wen/cfg_wdata write active_cols (reset 64); columns at or above it
//   are dead on input and zero on output. Write only between grids.
//   Reset drops any held rows and pending beats.
//   When m_tready is low, results collect in a two-entry buffer; s_tready
//   falls once it is full and rises as soon as a beat drains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "life_generation_row_stream_assert.svh"

module life_generation_row_stream
  import lgrs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // config
  input  wire logic                cfg_wen,
  input  wire logic [COLS_W-1:0]   cfg_wdata,    // active_cols
  // input rows
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [MAX_COLS-1:0] s_tdata,      // [63:0] row_cells
  input  wire logic                s_tlast,      // last_row
  // next-generation rows
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [MAX_COLS-1:0]      m_tdata,      // [63:0] next_row_cells
  output logic                     m_tlast       // frame_end
);

  logic [COLS_W-1:0]   active_cols;
  logic                middle_valid;
  logic                flush_pending;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] row_masked;
  logic [MAX_COLS-1:0] next_cells;
  logic                accept_in;
  logic                flush_go;
  logic                push;
  lgrs_ctrl_t          ctrl;
  lgrs_result_t        push_data;
  lgrs_result_t        m_beat;
  lgrs_buf_stat_t      buf_stat;
  lgrs_tap_t           taps [0:MAX_COLS+1];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_cols <= COLS_W'(MAX_COLS);
    end else if (cfg_wen) begin
      active_cols <= cfg_wdata;
    end
  end

  // per-column width mask
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (active_cols > COLS_W'(c));
    end
  end

  assign row_masked = s_tdata & col_mask;

  // handshake and command
  assign s_tready  = !flush_pending && buf_stat.can_push;
  assign accept_in = s_tvalid && s_tready;
  assign flush_go  = flush_pending && buf_stat.can_push;

  always_comb begin
    ctrl.flush  = flush_pending;
    ctrl.single = !middle_valid;
    ctrl.shift  = accept_in && (!s_tlast || middle_valid);
    ctrl.clear  = flush_go || (accept_in && s_tlast && !middle_valid);
    push        = flush_go || (accept_in && (middle_valid || s_tlast));
    push_data.cells     = next_cells;
    push_data.frame_end = flush_pending || (accept_in && s_tlast && !middle_valid);
  end

  // row-held and bottom-flush flags
  always_ff @(posedge clk) begin
    if (rst) begin
      middle_valid  <= 1'b0;
      flush_pending <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        middle_valid <= 1'b0;
      end else if (ctrl.shift) begin
        middle_valid <= 1'b1;
      end
      if (flush_go) begin
        flush_pending <= 1'b0;
      end else if (accept_in && s_tlast && middle_valid) begin
        flush_pending <= 1'b1;
      end
    end
  end

  // column chain; dead columns beyond both edges
  assign taps[0]          = '0;
  assign taps[MAX_COLS+1] = '0;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    lgrs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .row_bit   (row_masked[c]),
      .mask_bit  (col_mask[c]),
      .left_tap  (taps[c]),
      .right_tap (taps[c+2]),
      .tap       (taps[c+1]),
      .next_bit  (next_cells[c])
    );
  end

  // result buffer
  lgrs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .stat      (buf_stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_beat    (m_beat)
  );

  assign m_tdata = m_beat.cells;
  assign m_tlast = m_beat.frame_end;

  // checks
  `LGRS_ASSERT_NXT(a_bottom_sets_flush, accept_in && s_tlast && middle_valid, flush_pending)
  `LGRS_ASSERT_NXT(a_flush_clears, flush_go, !flush_pending && !middle_valid)
  `LGRS_ASSERT_IMP(a_flush_has_row, flush_pending, middle_valid)
  `LGRS_ASSERT_NXT(a_push_shows_beat, push, m_tvalid)
  `LGRS_ASSERT_IMP(a_buf_bound, 1'b1, buf_stat.count != 2'd3)

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench: life generation row stream
// Streams grids of rows through the block and checks every next-generation
// beat against a B3/S23 row predictor held in the bench. Covers
// single-row and longer grids and widths from 0 up to 127. Both stream sides
// see random idle gaps and stalls.
// ---------------------------------------------------------------------------

module testbench;
  import lgrs_pkg::*;

  // kinds of queued stimulus
  typedef enum logic [1:0] {
    OP_ROW,    // one grid row beat
    OP_WIDTH,  // active_cols write once the block is idle
    OP_DRAIN   // hold the sender until every result is in
  } grid_op_kind_t;

  typedef struct packed {
    grid_op_kind_t       kind;
    logic [MAX_COLS-1:0] cells;
    logic                last;
  } grid_op_t;

  typedef struct packed {
    logic [MAX_COLS-1:0] cells;
    logic                frame_end;
  } gen_row_t;

  localparam int unsigned SETTLE_CYCLES = 4;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_wen   = 1'b0;
  logic [COLS_W-1:0]   cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [MAX_COLS-1:0] s_tdata   = '0;
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [MAX_COLS-1:0] m_tdata;
  logic                m_tlast;

  grid_op_t    grid_ops_q[$];
  gen_row_t    next_rows_q[$];
  int unsigned mismatches = 0;
  int unsigned rows_queued = 0;
  int unsigned rows_taken = 0;
  logic        row_taken = 1'b0;

  // predictor state
  logic [COLS_W-1:0]   active_cols = COLS_W'(MAX_COLS);
  logic [MAX_COLS-1:0] held_above  = '0;
  logic [MAX_COLS-1:0] held_middle = '0;
  logic                middle_held = 1'b0;

  // idle pacing state for both sides
  int unsigned send_gap   = 0;
  int unsigned send_calm  = 0;
  int unsigned recv_gap   = 0;
  int unsigned recv_calm  = 0;
  int unsigned idle_span  = 0;

  life_generation_row_stream u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // live columns for a width; anything past MAX_COLS means all columns
  function automatic logic [MAX_COLS-1:0] col_mask(input logic [COLS_W-1:0] cols);
    if (cols >= MAX_COLS) return '1;
    return (64'd1 << cols) - 64'd1;
  endfunction

  // next generation of the middle row from its two neighbor rows
  function automatic logic [MAX_COLS-1:0] life_next_row(
      input logic [MAX_COLS-1:0] above, input logic [MAX_COLS-1:0] mid,
      input logic [MAX_COLS-1:0] below, input logic [MAX_COLS-1:0] mask);
    logic [MAX_COLS-1:0] taps [8];
    logic [MAX_COLS-1:0] born;
    int unsigned         live;
    taps[0] = above << 1;
    taps[1] = above;
    taps[2] = above >> 1;
    taps[3] = mid << 1;
    taps[4] = mid >> 1;
    taps[5] = below << 1;
    taps[6] = below;
    taps[7] = below >> 1;
    born = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      live = 0;
      for (int k = 0; k < 8; k++) live += taps[k][c];
      if (live == BIRTH_COUNT || (mid[c] && live == SURVIVE_COUNT)) born[c] = 1'b1;
    end
    return born & mask;
  endfunction

  // advance the predictor by one accepted row and queue its results
  task automatic take_row(input logic [MAX_COLS-1:0] cells_in, input logic last);
    logic [MAX_COLS-1:0] mask;
    logic [MAX_COLS-1:0] row;
    gen_row_t            res;
    mask = col_mask(active_cols);
    row  = cells_in & mask;
    if (middle_held) begin
      res.cells     = life_next_row(held_above, held_middle, row, mask);
      res.frame_end = 1'b0;
      next_rows_q.push_back(res);
      if (last) begin
        res.cells     = life_next_row(held_middle, row, '0, mask);
        res.frame_end = 1'b1;
        next_rows_q.push_back(res);
      end
    end else if (last) begin
      res.cells     = life_next_row('0, row, '0, mask);
      res.frame_end = 1'b1;
      next_rows_q.push_back(res);
    end
    if (last) begin
      held_above  = '0;
      held_middle = '0;
      middle_held = 1'b0;
    end else begin
      held_above  = middle_held ? held_middle : '0;
      held_middle = row;
      middle_held = 1'b1;
    end
  endtask

  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int unsigned draw_pause(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // row content with varied density
  function automatic logic [MAX_COLS-1:0] rand_row_cells();
    logic [MAX_COLS-1:0] a;
    logic [MAX_COLS-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return a & b;
      4:       return a & b & {$urandom, $urandom};
      5:       return a | b;
      default: return a;
    endcase
  endfunction

  task automatic add_row(input logic [MAX_COLS-1:0] cells, input logic last);
    grid_op_t op;
    op.kind  = OP_ROW;
    op.cells = cells;
    op.last  = last;
    grid_ops_q.push_back(op);
    rows_queued++;
  endtask

  task automatic add_width(input logic [COLS_W-1:0] cols);
    grid_op_t op;
    op.kind  = OP_WIDTH;
    op.cells = MAX_COLS'(cols);
    op.last  = 1'b0;
    grid_ops_q.push_back(op);
  endtask

  task automatic add_drain();
    grid_op_t op;
    op.kind  = OP_DRAIN;
    op.cells = '0;
    op.last  = 1'b0;
    grid_ops_q.push_back(op);
  endtask

  // whole grid of random rows, bottom row marked
  task automatic add_grid(input int unsigned rows);
    for (int unsigned i = 0; i < rows; i++) add_row(rand_row_cells(), i == rows - 1);
  endtask

  // check result beats and track accepted rows
  always @(posedge clk) begin : check_beats
    gen_row_t want;
    row_taken <= s_tvalid && s_tready && !rst;
    if (rst) begin
      active_cols = COLS_W'(MAX_COLS);
      held_above  = '0;
      held_middle = '0;
      middle_held = 1'b0;
    end else begin
      if (cfg_wen) active_cols = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (next_rows_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got cells %h last %b",
                   $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = next_rows_q.pop_front();
          if (m_tdata !== want.cells) begin
            $display("%0t: next_row_cells expected %h got %h", $time, want.cells, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.frame_end) begin
            $display("%0t: frame_end expected %b got %b", $time, want.frame_end, m_tlast);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        take_row(s_tdata, s_tlast);
        rows_taken++;
      end
    end
  end

  // drive row beats and width writes from the queue
  always @(negedge clk) begin : drive_rows
    grid_op_t            op;
    logic                valid_n;
    logic [MAX_COLS-1:0] data_n;
    logic                last_n;
    logic                wen_n;
    logic [COLS_W-1:0]   wdata_n;
    valid_n = s_tvalid;
    data_n  = s_tdata;
    last_n  = s_tlast;
    wen_n   = 1'b0;
    wdata_n = cfg_wdata;
    if (rst) begin
      valid_n = 1'b0;
    end else begin
      if (next_rows_q.size() == 0 && !(s_tvalid && !row_taken)) idle_span++;
      else idle_span = 0;
      if (s_tvalid && !row_taken) begin
        // hold the beat until it is taken
      end else if (send_gap > 0) begin
        valid_n = 1'b0;
        send_gap--;
      end else begin
        valid_n = 1'b0;
        if (grid_ops_q.size() > 0) begin
          op = grid_ops_q[0];
          case (op.kind)
            OP_ROW: begin
              void'(grid_ops_q.pop_front());
              valid_n  = 1'b1;
              data_n   = op.cells;
              last_n   = op.last;
              send_gap = draw_pause(send_calm);
            end
            OP_WIDTH: begin
              if (idle_span >= SETTLE_CYCLES) begin
                void'(grid_ops_q.pop_front());
                wen_n   = 1'b1;
                wdata_n = op.cells[COLS_W-1:0];
              end
            end
            default: begin
              if (next_rows_q.size() == 0) void'(grid_ops_q.pop_front());
            end
          endcase
        end
      end
    end
    s_tvalid  <= valid_n;
    s_tdata   <= data_n;
    s_tlast   <= last_n;
    cfg_wen   <= wen_n;
    cfg_wdata <= wdata_n;
  end

  // random stalls on the result side
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      recv_gap = draw_pause(recv_calm);
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned pick;
    int unsigned rows;
    logic        drained;
    drained = 1'b0;

    // directed: single-row grid, full rows, edge columns, checkerboards
    add_row('1, 1'b1);
    add_row('1, 1'b0);
    add_row('1, 1'b0);
    add_row('1, 1'b1);
    add_row(64'h8000_0000_0000_0001, 1'b0);
    add_row(64'hC000_0000_0000_0003, 1'b0);
    add_row(64'h0000_0038_0000_0000, 1'b1);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_row(64'h5555_5555_5555_5555, 1'b1);
    // narrowest legal width, then tiny and oversized widths
    add_width(7'd3);
    add_row('1, 1'b0);
    add_row('1, 1'b0);
    add_row('1, 1'b1);
    add_width(7'd0);
    add_row('1, 1'b0);
    add_row('1, 1'b1);
    add_width(7'd1);
    add_row('1, 1'b1);
    add_width(7'd2);
    add_row('1, 1'b0);
    add_row('1, 1'b1);
    add_width(7'd127);
    add_grid(3);
    add_width(7'd65);
    add_grid(2);
    add_width(7'd64);

    // random grids, with occasional width changes between them
    while (rows_queued < 1500) begin
      if ($urandom_range(0, 7) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      add_width(COLS_W'($urandom_range(3, 64)));
        else if (pick < 7) add_width(7'd64);
        else if (pick < 8) add_width(7'd3);
        else if (pick < 9) add_width(COLS_W'($urandom_range(0, 2)));
        else               add_width(COLS_W'($urandom_range(65, 127)));
      end
      if (!drained && rows_queued >= 750) begin
        add_drain();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) rows = $urandom_range(9, 40);
      else rows = $urandom_range(1, 8);
      add_grid(rows);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every queued row to be accepted, then for every result
    while (rows_taken < rows_queued) @(posedge clk);
    @(posedge clk);
    while (next_rows_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("life_generation_row_stream test passed");
    end else begin
      $display("life_generation_row_stream test failed");
    end
    $finish;
  end

  // hard stop for a hung run
  initial begin
    #10_000_000;
    $display("life_generation_row_stream test failed");
    $finish;
  end

endmodule
